FILE: rtl/core/lowpass_decimate_window_frontend_top_defines.svh
// assertion macros shared by the rtl core
`ifndef LOWPASS_DECIMATE_WINDOW_FRONTEND_TOP_DEFINES_SVH
`define LOWPASS_DECIMATE_WINDOW_FRONTEND_TOP_DEFINES_SVH

// same-cycle implication on clk, off while in reset
`define LDW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while in reset
`define LDW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ldw_pkg.sv
// shared types, constants and register map of the filter / window front end
package ldw_pkg;

	localparam int DECIMATION_DEF    = 4;
	localparam int WINDOW_LENGTH_DEF = 4096;

	localparam int SAMPLE_W   = 16;
	localparam int POS_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_PREV1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_PREV2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE    = 2'd2;

	localparam logic signed [CFG_DATA_W-1:0] FEEDBACK_PREV1_RST = -16'sd15449;
	localparam logic signed [CFG_DATA_W-1:0] FEEDBACK_PREV2_RST = 16'sd5462;
	localparam logic [CFG_DATA_W-1:0]        INPUT_SCALE_RST    = 16'd6397;

	// odd sine series coefficients, q30
	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598668;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172273;

	// one multiply each on the shared multiplier
	typedef enum logic [3:0] {
		OP_SCALE,
		OP_FB1,
		OP_FB2,
		OP_UR,
		OP_QL,
		OP_ZZ,
		OP_P7,
		OP_P5,
		OP_P3,
		OP_P1,
		OP_PZ,
		OP_FW
	} ldw_op_t;

	typedef struct packed {
		logic    load_in;
		logic    mul_en;
		logic    wb_en;
		logic    fin_en;
		ldw_op_t op;
	} ldw_cmd_t;

	typedef struct packed {
		logic emit;
		logic out_free;
	} ldw_sts_t;

endpackage

FILE: rtl/core/lowpass_decimate_window_frontend_top.sv
// top level of the low-pass, decimate and sine-window front end
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  input    | in_valid / in_ready       | audio_sample
//  output   | out_valid / out_ready     | windowed_sample, window_position, frame_last
//  config   | cfg_wr_en (no stall)      | cfg_index, cfg_wr_data
//
//  one sample at a time through a single shared 32x18 multiplier, every product
//  registered before use; a sample that starts a decimation group takes 9 more
//  multiplies for the window
//  reset clears filter history, decimation phase, window position and loads the
//  register defaults; the work registers carry no reset
//  a result waiting in the output register does not block the next input transfer;
//  only the final window multiply waits when the output slot is still full
module lowpass_decimate_window_frontend_top #(
	parameter int DECIMATION    = ldw_pkg::DECIMATION_DEF,
	parameter int WINDOW_LENGTH = ldw_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample input
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ldw_pkg::SAMPLE_W-1:0] audio_sample,
	// windowed result
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ldw_pkg::SAMPLE_W-1:0] windowed_sample,
	output logic [ldw_pkg::POS_W-1:0]           window_position,
	output logic                                frame_last,
	// register writes, allowed only while no sample is in flight
	input  logic                                cfg_wr_en,
	input  logic [ldw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ldw_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

	// command from the sequencer, status back from the datapath
	ldw_pkg::ldw_cmd_t cmd;
	ldw_pkg::ldw_sts_t sts;

	// sequencer: scale, two feedback products, filter update, then the
	// window chain (reciprocal, correction, z^2, four series steps, scale, product)
	ldw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// multiplier, biquad history, window arithmetic and output register
	ldw_datapath #(
		.DECIMATION    (DECIMATION),
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wr_data     (cfg_wr_data),
		.audio_sample    (audio_sample),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.windowed_sample (windowed_sample),
		.window_position (window_position),
		.frame_last      (frame_last)
	);

endmodule

FILE: rtl/core/ldw_ctrl.sv
// sequencer for the shared multiplier: issue / writeback per operation
`include "lowpass_decimate_window_frontend_top_defines.svh"

module ldw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ldw_pkg::ldw_sts_t sts,
	output ldw_pkg::ldw_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WB,
		ST_FIN
	} state_t;

	state_t          state_q;
	ldw_pkg::ldw_op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= ldw_pkg::OP_SCALE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ISSUE;
						op_q    <= ldw_pkg::OP_SCALE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (op_q == ldw_pkg::OP_FB2) begin
						state_q <= ST_FIN;
					end else if (op_q == ldw_pkg::OP_FW) begin
						// final product waits for a free output slot
						if (sts.out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_ISSUE;
					end
					case (op_q)
						ldw_pkg::OP_SCALE: op_q <= ldw_pkg::OP_FB1;
						ldw_pkg::OP_FB1:   op_q <= ldw_pkg::OP_FB2;
						ldw_pkg::OP_UR:    op_q <= ldw_pkg::OP_QL;
						ldw_pkg::OP_QL:    op_q <= ldw_pkg::OP_ZZ;
						ldw_pkg::OP_ZZ:    op_q <= ldw_pkg::OP_P7;
						ldw_pkg::OP_P7:    op_q <= ldw_pkg::OP_P5;
						ldw_pkg::OP_P5:    op_q <= ldw_pkg::OP_P3;
						ldw_pkg::OP_P3:    op_q <= ldw_pkg::OP_P1;
						ldw_pkg::OP_P1:    op_q <= ldw_pkg::OP_PZ;
						ldw_pkg::OP_PZ:    op_q <= ldw_pkg::OP_FW;
						default: begin
						end
					endcase
				end
				ST_FIN: begin
					if (sts.emit) begin
						state_q <= ST_ISSUE;
						op_q    <= ldw_pkg::OP_UR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.load_in = in_valid && (state_q == ST_IDLE);
		cmd.mul_en  = (state_q == ST_ISSUE);
		cmd.wb_en   = (state_q == ST_WB) && ((op_q != ldw_pkg::OP_FW) || sts.out_free);
		cmd.fin_en  = (state_q == ST_FIN);
		cmd.op      = op_q;
	end

	`LDW_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, cmd.mul_en && (cmd.op == ldw_pkg::OP_SCALE), "no scaling")
	`LDW_ASSERT_SAME(a_idle_quiet, in_ready, !cmd.mul_en && !cmd.wb_en && !cmd.fin_en, "command while idle")
	`LDW_ASSERT_SAME(a_fw_slot, cmd.wb_en && (cmd.op == ldw_pkg::OP_FW), sts.out_free, "result overwritten")

endmodule

FILE: rtl/core/ldw_datapath.sv
// shared multiplier, filter state, window evaluation and output register
`include "lowpass_decimate_window_frontend_top_defines.svh"

module ldw_datapath #(
	parameter int DECIMATION    = ldw_pkg::DECIMATION_DEF,
	parameter int WINDOW_LENGTH = ldw_pkg::WINDOW_LENGTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [ldw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ldw_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
	input  logic signed [ldw_pkg::SAMPLE_W-1:0]   audio_sample,
	input  ldw_pkg::ldw_cmd_t                     cmd,
	output ldw_pkg::ldw_sts_t                     sts,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ldw_pkg::SAMPLE_W-1:0]   windowed_sample,
	output logic [ldw_pkg::POS_W-1:0]             window_position,
	output logic                                  frame_last
);

	localparam int SW     = ldw_pkg::SAMPLE_W;
	localparam int PSW    = ldw_pkg::POS_W;
	localparam int HW     = 24;
	localparam int ACC_W  = 30;
	localparam int FB_W   = 41;
	localparam int A_W    = 32;
	localparam int B_W    = 18;
	localparam int P_W    = A_W + B_W;
	localparam int Z_W    = 17;
	localparam int NUM_W  = 31;
	localparam int CW     = ($clog2(WINDOW_LENGTH) > PSW) ? $clog2(WINDOW_LENGTH) : PSW;
	localparam int PW     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam int UW     = $clog2(WINDOW_LENGTH / 2 + 1);
	localparam logic [22:0] RECIP = 23'((64'd1 << 30) / WINDOW_LENGTH);

	// configuration
	logic signed [SW-1:0] fb1_q;
	logic signed [SW-1:0] fb2_q;
	logic [SW-1:0]        scale_q;

	// filter state
	logic signed [HW-1:0] x_hist_q [2];
	logic signed [HW-1:0] y_hist_q [2];
	logic [PW-1:0]        phase_q;
	logic [CW-1:0]        cnt_q;
	logic                 out_valid_q;

	// per-sample work registers
	logic signed [SW-1:0]   s_q;
	logic signed [P_W-1:0]  mul_q;
	logic signed [HW-1:0]   x_q;
	logic signed [FB_W-1:0] fb_acc_q;
	logic [UW-1:0]          u_q;
	logic [Z_W-1:0]         q0_q;
	logic [Z_W-1:0]         z_q;
	logic [Z_W-1:0]         z2_q;
	logic [30:0]            p_q;
	logic [14:0]            w_q;
	logic signed [SW-1:0]   f_q;
	logic signed [SW-1:0]   windowed_q;
	logic [PSW-1:0]         pos_q;
	logic                   last_q;

	logic signed [A_W-1:0]  mul_a;
	logic signed [B_W-1:0]  mul_b;
	logic signed [26:0]     fb_shift;
	logic signed [ACC_W-1:0] acc;
	logic signed [HW-1:0]   y_sat;
	logic signed [HW-1:0]   y_adj;
	logic [CW:0]            twice_cnt;
	logic [UW-1:0]          u_next;
	logic [NUM_W-1:0]       num;
	logic [NUM_W-1:0]       rem;
	logic [30:0]            c_sel;
	logic [32:0]            pz_round;
	logic [17:0]            w_pre;
	logic signed [16:0]     prod;
	logic signed [SW-1:0]   prod_sat;

	// operand select for the shared multiplier
	always_comb begin
		case (cmd.op) inside
			ldw_pkg::OP_SCALE: begin
				mul_a = A_W'(s_q);
				mul_b = B_W'(scale_q);
			end
			ldw_pkg::OP_FB1: begin
				mul_a = A_W'(y_hist_q[0]);
				mul_b = B_W'(fb1_q);
			end
			ldw_pkg::OP_FB2: begin
				mul_a = A_W'(y_hist_q[1]);
				mul_b = B_W'(fb2_q);
			end
			ldw_pkg::OP_UR: begin
				mul_a = A_W'(RECIP);
				mul_b = B_W'(u_q);
			end
			ldw_pkg::OP_QL: begin
				mul_a = A_W'(q0_q);
				mul_b = B_W'(WINDOW_LENGTH);
			end
			ldw_pkg::OP_ZZ: begin
				mul_a = A_W'(z_q);
				mul_b = B_W'(z_q);
			end
			ldw_pkg::OP_P7, ldw_pkg::OP_P5, ldw_pkg::OP_P3, ldw_pkg::OP_P1: begin
				mul_a = A_W'(p_q);
				mul_b = B_W'(z2_q);
			end
			ldw_pkg::OP_PZ: begin
				mul_a = A_W'(p_q);
				mul_b = B_W'(z_q);
			end
			ldw_pkg::OP_FW: begin
				mul_a = A_W'(f_q);
				mul_b = B_W'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// filter update and window argument
	always_comb begin
		fb_shift = $signed(fb_acc_q[FB_W-1:14]);
		acc = ACC_W'(x_q) + (ACC_W'(x_hist_q[0]) <<< 1) + ACC_W'(x_hist_q[1])
			- ACC_W'(fb_shift);
		if (acc > 30'sd8388607) begin
			y_sat = 24'sh7FFFFF;
		end else if (acc < -30'sd8388608) begin
			y_sat = 24'sh800000;
		end else begin
			y_sat = acc[HW-1:0];
		end
		twice_cnt = {cnt_q, 1'b0};
		if (twice_cnt <= (CW + 1)'(WINDOW_LENGTH)) begin
			u_next = UW'(cnt_q);
		end else begin
			u_next = UW'((CW + 1)'(WINDOW_LENGTH) - {1'b0, cnt_q});
		end
	end

	// writeback helpers
	always_comb begin
		// truncate toward zero
		y_adj = y_hist_q[0] + (y_hist_q[0][HW-1] ? 24'sd255 : 24'sd0);
		num   = NUM_W'({u_q, 17'b0});
		rem   = num - mul_q[NUM_W-1:0];
		case (cmd.op)
			ldw_pkg::OP_P7: c_sel = ldw_pkg::SIN_C7;
			ldw_pkg::OP_P5: c_sel = ldw_pkg::SIN_C5;
			ldw_pkg::OP_P3: c_sel = ldw_pkg::SIN_C3;
			default:        c_sel = ldw_pkg::SIN_C1;
		endcase
		pz_round = {1'b0, mul_q[47:16]} + 33'd16384;
		w_pre    = pz_round[32:15];
		prod     = $signed(mul_q[31:15]);
		if (prod > 17'sd32767) begin
			prod_sat = 16'sh7FFF;
		end else if (prod < -17'sd32768) begin
			prod_sat = 16'sh8000;
		end else begin
			prod_sat = prod[SW-1:0];
		end
	end

	// configuration and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb1_q       <= ldw_pkg::FEEDBACK_PREV1_RST;
			fb2_q       <= ldw_pkg::FEEDBACK_PREV2_RST;
			scale_q     <= ldw_pkg::INPUT_SCALE_RST;
			x_hist_q[0] <= '0;
			x_hist_q[1] <= '0;
			y_hist_q[0] <= '0;
			y_hist_q[1] <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					ldw_pkg::REG_FEEDBACK_PREV1: fb1_q   <= cfg_wr_data;
					ldw_pkg::REG_FEEDBACK_PREV2: fb2_q   <= cfg_wr_data;
					ldw_pkg::REG_INPUT_SCALE:    scale_q <= cfg_wr_data;
					default: begin
					end
				endcase
			end
			if (cmd.fin_en) begin
				x_hist_q[1] <= x_hist_q[0];
				x_hist_q[0] <= x_q;
				y_hist_q[1] <= y_hist_q[0];
				y_hist_q[0] <= y_sat;
				if (phase_q == PW'(DECIMATION - 1)) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + PW'(1);
				end
			end
			if (cmd.wb_en && (cmd.op == ldw_pkg::OP_FW)) begin
				out_valid_q <= 1'b1;
				if (cnt_q == CW'(WINDOW_LENGTH - 1)) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			s_q <= audio_sample;
		end
		if (cmd.mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.fin_en) begin
			u_q <= u_next;
		end
		if (cmd.wb_en) begin
			case (cmd.op) inside
				ldw_pkg::OP_SCALE: x_q      <= $signed(mul_q[31:8]);
				ldw_pkg::OP_FB1:   fb_acc_q <= $signed(mul_q[FB_W-1:0]);
				ldw_pkg::OP_FB2:   fb_acc_q <= fb_acc_q + $signed(mul_q[FB_W-1:0]);
				ldw_pkg::OP_UR: begin
					q0_q <= mul_q[29:13];
					f_q  <= $signed(y_adj[HW-1:8]);
				end
				ldw_pkg::OP_QL: begin
					// reciprocal estimate is at most one low
					if (rem >= NUM_W'(WINDOW_LENGTH)) begin
						z_q <= q0_q + Z_W'(1);
					end else begin
						z_q <= q0_q;
					end
				end
				ldw_pkg::OP_ZZ: begin
					z2_q <= mul_q[32:16];
					p_q  <= ldw_pkg::SIN_C9;
				end
				ldw_pkg::OP_P7, ldw_pkg::OP_P5, ldw_pkg::OP_P3, ldw_pkg::OP_P1: begin
					p_q <= c_sel - mul_q[46:16];
				end
				ldw_pkg::OP_PZ: begin
					w_q <= (w_pre > 18'd32767) ? 15'h7FFF : w_pre[14:0];
				end
				ldw_pkg::OP_FW: begin
					windowed_q <= prod_sat;
					pos_q      <= cnt_q[PSW-1:0];
					last_q     <= (cnt_q == CW'(WINDOW_LENGTH - 1));
				end
				default: begin
				end
			endcase
		end
	end

	assign sts.emit        = (phase_q == '0);
	assign sts.out_free    = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign windowed_sample = windowed_q;
	assign window_position = pos_q;
	assign frame_last      = last_q;

	`LDW_ASSERT_NEXT(a_fw_sets_valid, cmd.wb_en && (cmd.op == ldw_pkg::OP_FW), out_valid_q, "no result")
	`LDW_ASSERT_NEXT(a_z_range, cmd.wb_en && (cmd.op == ldw_pkg::OP_QL), z_q <= 17'h10000, "z too big")
	`LDW_ASSERT_SAME(a_phase_range, 1'b1, phase_q <= PW'(DECIMATION - 1), "phase out of range")

endmodule
